FILE: hdl/rukf_pkg.sv
// Shared types, codes and constant tables for the row upscale kernel filter.
package rukf_pkg;

    // Field widths of the stream payloads.
    localparam int INDEX_W    = 11;
    localparam int PIXEL_W    = 8;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Request kinds carried in s_tuser.
    localparam logic REQ_STORE   = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    // Kernel selection codes.
    localparam logic [2:0] KER_BOX      = 3'd0;
    localparam logic [2:0] KER_TENT     = 3'd1;
    localparam logic [2:0] KER_GAUSS    = 3'd2;
    localparam logic [2:0] KER_BELL     = 3'd3;
    localparam logic [2:0] KER_MITCHELL = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;

    // Configuration reset values.
    localparam logic [2:0]            KERNEL_RESET = KER_TENT;
    localparam logic [3:0]            FACTOR_RESET = 4'd2;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd256;

    // Gaussian samples at steps of 1/8, Q2.14.
    localparam int GAUSS_LAST = 32;
    localparam logic [15:0] GAUSS_Q14 [0:GAUSS_LAST] = '{
        16'd6536, 16'd6485, 16'd6335, 16'd6092, 16'd5768, 16'd5377, 16'd4934, 16'd4457,
        16'd3964, 16'd3471, 16'd2993, 16'd2540, 16'd2122, 16'd1746, 16'd1414, 16'd1127,
        16'd885,  16'd684,  16'd520,  16'd389,  16'd287,  16'd208,  16'd149,  16'd105,
        16'd73,   16'd50,   16'd33,   16'd22,   16'd14,   16'd9,    16'd6,    16'd4,
        16'd2
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_READ,
        ST_SQUARE,
        ST_HALFSQ,
        ST_CUBE,
        ST_POLY,
        ST_RECIP,
        ST_WEIGHT,
        ST_MAC,
        ST_ACC,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/row_upscale_kernel_filter_top.sv
// Top level of the row upscale kernel filter: sequencer, shared multiplier and row buffer.
//
// Usage: the slave stream carries requests. s_tuser[0] selects a store (write
// pixel_value at pixel_index into the row buffer) or a compute (produce output
// pixel pixel_index of the upscaled row). A store makes no result, so stores
// can stream back to back. A compute makes exactly one result on the master
// stream: the filtered pixel in m_tdata and the out-of-range flag in
// m_tuser[0].
// A compute runs a bit-serial long division of the output index by the
// factor, a setup step, then per tap the states read, square, half square,
// cube, poly, recip, weight, MAC and acc on the single shared multiplier
// (square, cube, bell square, reciprocal of 18, pixel times weight), and a
// final step to saturate. A compute has at most factor + 1 taps; an
// out-of-range index skips the division and goes straight to the final step.
// The result sits in an output register, so new stores are taken while it
// waits; a following compute holds in its final cycle until the receiver
// takes the previous result. Configuration is a plain write port and should
// only be written while no compute is in flight.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties the
// output register and loads the register defaults; the row buffer keeps its
// contents and must be written before it is read.
module row_upscale_kernel_filter_top #(
    parameter int ROW_PIXELS       = 256,
    parameter int MAX_FACTOR       = 8,
    parameter int WEIGHT_FRAC_BITS = 14
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [10:0] pixel_index, [18:11] pixel_value, [23:19] zero
    input  logic [rukf_pkg::S_TDATA_W-1:0]      s_tdata,
    // [0] req_type
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] pixel_out
    output logic [rukf_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] out_of_range
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic [rukf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rukf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int W     = WEIGHT_FRAC_BITS;
    localparam int ONE   = 1 << W;
    localparam int XW    = rukf_pkg::INDEX_W;
    localparam int IW    = $clog2(ROW_PIXELS);
    localparam int KW    = (IW > XW) ? IW : XW;
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int WDW   = $clog2(ROW_PIXELS + 1);
    localparam int CW    = (WDW > rukf_pkg::CFG_DATA_W) ? WDW : rukf_pkg::CFG_DATA_W;
    localparam int QW    = XW + W;
    localparam int DCW   = $clog2(QW);
    localparam int SW    = KW + 2;
    localparam int DW    = KW + W + 1;
    localparam int AW    = W + 3;
    localparam int A2W   = W + 5;
    localparam int A3W   = W + 7;
    localparam int BLW   = W + 1;
    localparam int WW    = W + 2;
    localparam int NW    = W + 16;
    localparam int NB    = W + 9;
    localparam int S18   = NB + 5;
    localparam int QDW   = NB - 4;
    localparam int MW    = W + 11;
    localparam int PW    = 2 * MW;
    localparam int ACCW  = W + 16;
    localparam int GIW   = W + 7;
    localparam int GSHL  = (W >= 14) ? W - 14 : 0;
    localparam int GSHR  = (W >= 14) ? 0 : 14 - W;
    localparam int GW    = 16 + GSHL;
    localparam longint M18 = ((longint'(1) << S18) + 17) / 18;

    localparam logic [AW-1:0]  A_HALF      = AW'(ONE / 2);
    localparam logic [AW-1:0]  A_ONE       = AW'(ONE);
    localparam logic [AW-1:0]  A_THREEHALF = AW'((3 * ONE) / 2);
    localparam logic [AW-1:0]  A_TWO       = AW'(2 * ONE);
    localparam logic [AW-1:0]  A_SAT       = AW'(5 * ONE);
    localparam logic [A2W-1:0] A2_3Q       = A2W'((3 * ONE) / 4);

    rukf_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [2:0]                      cfg_kernel_reg;
    logic [3:0]                      cfg_factor_reg;
    logic [rukf_pkg::CFG_DATA_W-1:0] cfg_width_reg;

    logic [FW-1:0]  f_eff;
    logic [WDW-1:0] w_eff;

    // Input decode.
    logic          in_req;
    logic [XW-1:0] in_index;
    logic [7:0]    in_value;
    logic          in_accept;
    logic          in_oor;

    // Divider.
    logic [DCW-1:0] cnt_reg;
    logic [XW-1:0]  jsh_reg;
    logic [FW-1:0]  rem_reg, rem_new, jr_reg;
    logic [FW:0]    rem2;
    logic           div_ge;
    logic [QW-1:0]  quo_reg;

    // Tap loop.
    logic [IW-1:0]   k_reg, right_reg;
    logic [IW-1:0]   left_k, right_k;
    logic [AW-1:0]   a_reg, a_next;
    logic            neg_reg, neg_next;
    logic [A2W-1:0]  a2_reg;
    logic [BLW-1:0]  bell_reg;
    logic [NB-1:0]   num_abs_reg, num_abs_next;
    logic            num_neg_reg, num_neg_next;
    logic signed [WW-1:0]   weight_reg, weight_next;
    logic signed [ACCW-1:0] acc_reg;
    logic            oor_reg;

    // Shared multiplier.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p_reg, mul_p_next;

    // Row buffer.
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;

    // Output register.
    logic       m_valid_reg;
    logic [7:0] m_data_reg, res_sat;
    logic       m_user_reg;
    logic       out_load;

    assign in_req   = s_tuser[0];
    assign in_index = s_tdata[XW-1:0];
    assign in_value = s_tdata[XW+rukf_pkg::PIXEL_W-1:XW];
    assign in_accept = s_tvalid && s_tready;
    assign ram_waddr = IW'(in_index);

    // Factor and width as the datapath sees them.
    always_comb begin
        if (cfg_factor_reg == 4'd0) begin
            f_eff = FW'(1);
        end else if (5'(cfg_factor_reg) > 5'(MAX_FACTOR)) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(cfg_factor_reg);
        end
        if (cfg_width_reg == '0) begin
            w_eff = WDW'(1);
        end else if (CW'(cfg_width_reg) > CW'(ROW_PIXELS)) begin
            w_eff = WDW'(ROW_PIXELS);
        end else begin
            w_eff = WDW'(cfg_width_reg);
        end
    end

    assign in_oor = 32'(in_index) >= 32'(w_eff) * 32'(f_eff);

    // One step of restoring division of index * 2^W by the factor.
    always_comb begin
        rem2   = {rem_reg, jsh_reg[XW-1]};
        div_ge = rem2 >= {1'b0, f_eff};
        rem_new = div_ge ? FW'(rem2 - {1'b0, f_eff}) : FW'(rem2);
    end

    // Window bounds from the integer and remainder parts of index / factor.
    always_comb begin
        logic [XW-1:0]        jq;
        logic                 up;
        logic signed [SW-1:0] left_s, right_s, wm1;
        jq = quo_reg[QW-1:W];
        up = {jr_reg, 1'b0} >= {1'b0, f_eff};
        left_s  = SW'(jq) - SW'(f_eff >> 1) - SW'(f_eff[0] && !up);
        right_s = SW'(jq) + SW'(f_eff >> 1) + SW'(f_eff[0] && up);
        wm1     = SW'(w_eff) - SW'(1);
        left_k  = (left_s < 0) ? '0 : IW'(left_s);
        right_k = (right_s > wm1) ? IW'(wm1) : IW'(right_s);
    end

    // Tap offset magnitude: the tap lies left of the source position when
    // k * factor < index, and the rounding direction follows from that side.
    always_comb begin
        logic [KW-1:0] kx, jqx;
        logic [DW-1:0] lfix_x, lceil_x, kone, diff;
        kx  = KW'(k_reg);
        jqx = KW'(quo_reg[QW-1:W]);
        neg_next = (kx < jqx) || ((kx == jqx) && (jr_reg != '0));
        lfix_x  = DW'(quo_reg);
        lceil_x = lfix_x + DW'(rem_reg != '0);
        kone    = DW'(kx) << W;
        diff    = neg_next ? lfix_x - kone : kone - lceil_x;
        a_next  = (diff > DW'(5 * ONE)) ? A_SAT : AW'(diff);
    end

    // Mitchell-Netravali numerator; the cube arrives from the multiplier.
    always_comb begin
        logic signed [NW-1:0] a_s, a2_s, a3_s, num;
        a_s  = signed'(NW'(a_reg));
        a2_s = signed'(NW'(a2_reg));
        a3_s = signed'(NW'(mul_p_reg[W+A3W-1:W]));
        if (a_reg <= A_ONE) begin
            num = NW'(a3_s * 21 - a2_s * 36 + 16 * ONE);
        end else begin
            num = NW'(a2_s * 36 - a3_s * 7 - a_s * 60 + 32 * ONE);
        end
        num_neg_next = num < 0;
        num_abs_next = NB'(num_neg_next ? -num : num);
    end

    // Weight of the current tap for the selected kernel.
    always_comb begin
        logic [GIW-1:0] gsum;
        logic [6:0]     gidx;
        logic [15:0]    graw;
        logic [GW-1:0]  gtmp;
        logic signed [WW-1:0] gw, qw;
        gsum = GIW'({a_reg, 3'b000}) + GIW'(ONE / 2);
        gidx = gsum[GIW-1:W];
        graw = (gidx > 7'(rukf_pkg::GAUSS_LAST)) ? 16'd0 : rukf_pkg::GAUSS_Q14[gidx[5:0]];
        gtmp = (GW'(graw) << GSHL) >> GSHR;
        gw   = signed'(WW'(gtmp));
        qw   = signed'(WW'(mul_p_reg[S18+QDW-1:S18]));
        case (cfg_kernel_reg)
            rukf_pkg::KER_BOX: begin
                if (neg_reg ? (a_reg <= A_HALF) : (a_reg < A_HALF)) begin
                    weight_next = WW'(ONE);
                end else begin
                    weight_next = '0;
                end
            end
            rukf_pkg::KER_TENT: begin
                weight_next = (a_reg <= A_ONE) ? signed'(WW'(A_ONE - a_reg)) : '0;
            end
            rukf_pkg::KER_GAUSS: begin
                weight_next = gw;
            end
            rukf_pkg::KER_BELL: begin
                if (a_reg <= A_HALF) begin
                    weight_next = signed'(WW'(A2_3Q - a2_reg));
                end else if (a_reg <= A_THREEHALF) begin
                    weight_next = signed'(WW'(bell_reg));
                end else begin
                    weight_next = '0;
                end
            end
            rukf_pkg::KER_MITCHELL: begin
                weight_next = (a_reg <= A_TWO) ? (num_neg_reg ? -qw : qw) : '0;
            end
            default: begin
                weight_next = '0;
            end
        endcase
    end

    // Saturation of the accumulated sum.
    always_comb begin
        logic signed [ACCW-1:0] res_sh;
        res_sh = acc_reg >>> W;
        if (acc_reg < 0) begin
            res_sat = 8'd0;
        end else if (res_sh > ACCW'(255)) begin
            res_sat = 8'hFF;
        end else begin
            res_sat = res_sh[7:0];
        end
    end

    assign out_load = (state_reg == rukf_pkg::ST_FINISH) && (!m_valid_reg || m_tready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rukf_pkg::ST_IDLE: begin
                if (in_accept && in_req == rukf_pkg::REQ_COMPUTE) begin
                    state_next = in_oor ? rukf_pkg::ST_FINISH : rukf_pkg::ST_DIV;
                end
            end
            rukf_pkg::ST_DIV: begin
                if (cnt_reg == DCW'(QW - 1)) begin
                    state_next = rukf_pkg::ST_SETUP;
                end
            end
            rukf_pkg::ST_SETUP:  state_next = rukf_pkg::ST_READ;
            rukf_pkg::ST_READ:   state_next = rukf_pkg::ST_SQUARE;
            rukf_pkg::ST_SQUARE: state_next = rukf_pkg::ST_HALFSQ;
            rukf_pkg::ST_HALFSQ: state_next = rukf_pkg::ST_CUBE;
            rukf_pkg::ST_CUBE:   state_next = rukf_pkg::ST_POLY;
            rukf_pkg::ST_POLY:   state_next = rukf_pkg::ST_RECIP;
            rukf_pkg::ST_RECIP:  state_next = rukf_pkg::ST_WEIGHT;
            rukf_pkg::ST_WEIGHT: state_next = rukf_pkg::ST_MAC;
            rukf_pkg::ST_MAC:    state_next = rukf_pkg::ST_ACC;
            rukf_pkg::ST_ACC: begin
                state_next = (k_reg == right_reg) ? rukf_pkg::ST_FINISH : rukf_pkg::ST_READ;
            end
            rukf_pkg::ST_FINISH: begin
                if (out_load) begin
                    state_next = rukf_pkg::ST_IDLE;
                end
            end
            default: state_next = rukf_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, buffer port and multiplier operands.
    always_comb begin
        logic [AW-1:0] t;
        t = (a_reg >= A_THREEHALF) ? '0 : A_THREEHALF - a_reg;
        s_tready = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            rukf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                ram_we = s_tvalid && (in_req == rukf_pkg::REQ_STORE)
                         && (32'(in_index) < 32'(ROW_PIXELS));
            end
            rukf_pkg::ST_READ: begin
                ram_re = 1'b1;
            end
            rukf_pkg::ST_SQUARE: begin
                mul_a = MW'(a_reg);
                mul_b = MW'(a_reg);
            end
            rukf_pkg::ST_HALFSQ: begin
                mul_a = MW'(t);
                mul_b = MW'(t);
            end
            rukf_pkg::ST_CUBE: begin
                mul_a = MW'(a2_reg);
                mul_b = MW'(a_reg);
            end
            rukf_pkg::ST_RECIP: begin
                mul_a = MW'(num_abs_reg);
                mul_b = MW'(M18);
            end
            rukf_pkg::ST_MAC: begin
                mul_a = MW'(ram_rdata);
                mul_b = MW'(weight_reg);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p_next = PW'(mul_a) * PW'(mul_b);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rukf_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            cnt_reg        <= '0;
            cfg_kernel_reg <= rukf_pkg::KERNEL_RESET;
            cfg_factor_reg <= rukf_pkg::FACTOR_RESET;
            cfg_width_reg  <= rukf_pkg::WIDTH_RESET;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == rukf_pkg::ST_DIV) begin
                cnt_reg <= cnt_reg + DCW'(1);
            end else begin
                cnt_reg <= '0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    rukf_pkg::CFG_KERNEL: cfg_kernel_reg <= cfg_data[2:0];
                    rukf_pkg::CFG_FACTOR: cfg_factor_reg <= cfg_data[3:0];
                    rukf_pkg::CFG_WIDTH:  cfg_width_reg  <= cfg_data;
                    default: cfg_kernel_reg <= cfg_kernel_reg;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_p_next;
        case (state_reg)
            rukf_pkg::ST_IDLE: begin
                if (in_accept && in_req == rukf_pkg::REQ_COMPUTE) begin
                    jsh_reg <= in_index;
                    rem_reg <= '0;
                    oor_reg <= in_oor;
                    acc_reg <= '0;
                end
            end
            rukf_pkg::ST_DIV: begin
                jsh_reg <= {jsh_reg[XW-2:0], 1'b0};
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[QW-2:0], div_ge};
                // After the integer quotient bits the remainder is index mod factor.
                if (cnt_reg == DCW'(XW - 1)) begin
                    jr_reg <= rem_new;
                end
            end
            rukf_pkg::ST_SETUP: begin
                k_reg     <= left_k;
                right_reg <= right_k;
            end
            rukf_pkg::ST_READ: begin
                a_reg   <= a_next;
                neg_reg <= neg_next;
            end
            rukf_pkg::ST_HALFSQ: begin
                a2_reg <= mul_p_reg[W+A2W-1:W];
            end
            rukf_pkg::ST_CUBE: begin
                bell_reg <= mul_p_reg[W+BLW:W+1];
            end
            rukf_pkg::ST_POLY: begin
                num_abs_reg <= num_abs_next;
                num_neg_reg <= num_neg_next;
            end
            rukf_pkg::ST_WEIGHT: begin
                weight_reg <= weight_next;
            end
            rukf_pkg::ST_ACC: begin
                acc_reg <= acc_reg + ACCW'(mul_p_reg);
                if (k_reg != right_reg) begin
                    k_reg <= k_reg + IW'(1);
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
        if (out_load) begin
            m_data_reg <= oor_reg ? 8'd0 : res_sat;
            m_user_reg <= oor_reg;
        end
    end

    rukf_ram #(
        .WIDTH (rukf_pkg::PIXEL_W),
        .DEPTH (ROW_PIXELS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .re    (ram_re),
        .raddr (k_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

FILE: hdl/rukf_ram.sv
// Generic single write port RAM with a registered read port.
module rukf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the row upscale kernel filter: stream driver, monitor and predictor.
module tb;

    localparam int     ROW          = 256;
    localparam int     FRAC         = 14;
    localparam longint ONE          = 64'sd1 << FRAC;
    localparam int     PHASE_ITEMS  = 75;
    localparam int     LAST_PHASE   = 14;
    localparam int     SETTLE       = 120;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     QUIET_LIMIT  = 6000;

    // Kernel codes with no kernel behind them; the block must output zero for these.
    localparam logic [2:0] KER_UNDEF_A = 3'd5;
    localparam logic [2:0] KER_UNDEF_B = 3'd6;
    localparam logic [2:0] KER_UNDEF_C = 3'd7;

    localparam int PHASE_KERNEL [0:11] = '{rukf_pkg::KER_BOX, rukf_pkg::KER_MITCHELL,
        rukf_pkg::KER_GAUSS, rukf_pkg::KER_BELL, KER_UNDEF_C, rukf_pkg::KER_MITCHELL,
        rukf_pkg::KER_TENT, rukf_pkg::KER_BELL, rukf_pkg::KER_GAUSS, KER_UNDEF_A,
        KER_UNDEF_B, rukf_pkg::KER_BOX};
    localparam int PHASE_FACTOR [0:11] = '{1, 8, 8, 3, 0, 15, 5, 8, 1, 2, 4, 8};
    localparam int PHASE_WIDTH  [0:11] = '{1, 256, 255, 100, 0, 511, 37, 256, 256, 17, 300, 2};

    typedef struct {
        logic        kind;
        logic [10:0] index;
        logic [7:0]  value;
    } request_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       oor;
    } pixel_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rukf_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rukf_pkg::M_TDATA_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [rukf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rukf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: a copy of the row buffer and of the registers.
    logic [7:0] row_copy [0:ROW-1];
    logic [2:0] kern_sel = rukf_pkg::KERNEL_RESET;
    logic [3:0] factor_reg = rukf_pkg::FACTOR_RESET;
    logic [8:0] width_reg = rukf_pkg::WIDTH_RESET;

    request_t      pixel_requests[$];
    pixel_result_t predicted_pixels[$];
    int queued_count = 0;
    int accepted_count = 0;
    int failures = 0;
    bit idle_on = 1'b1;
    int hold_asked = 0;

    row_upscale_kernel_filter_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int active_factor();
        int f;
        f = (factor_reg == 0) ? 1 : int'(factor_reg);
        return (f > 8) ? 8 : f;
    endfunction

    function automatic int active_width();
        int w;
        w = (width_reg == 0) ? 1 : int'(width_reg);
        return (w > ROW) ? ROW : w;
    endfunction

    function automatic longint kernel_tap_weight(logic [2:0] kern, longint n, longint f);
        longint mag, a, a2, a3, t, gi;
        mag = (n < 0) ? -n : n;
        a = (mag * ONE) / f;
        a2 = (a * a) >>> FRAC;
        a3 = (a2 * a) >>> FRAC;
        case (kern)
            rukf_pkg::KER_BOX: begin
                return (2 * n >= -f && 2 * n < f) ? ONE : 64'sd0;
            end
            rukf_pkg::KER_TENT: begin
                return (a <= ONE) ? ONE - a : 64'sd0;
            end
            rukf_pkg::KER_GAUSS: begin
                // Round the offset to the nearest eighth and look it up.
                gi = (8 * a + ONE / 2) >>> FRAC;
                if (gi > rukf_pkg::GAUSS_LAST)
                    return 0;
                return longint'(rukf_pkg::GAUSS_Q14[gi]) <<< (FRAC - 14);
            end
            rukf_pkg::KER_BELL: begin
                if (a <= ONE / 2)
                    return (3 * ONE) / 4 - a2;
                if (a <= (3 * ONE) / 2) begin
                    t = (3 * ONE) / 2 - a;
                    return (t * t) >>> (FRAC + 1);
                end
                return 0;
            end
            rukf_pkg::KER_MITCHELL: begin
                if (a <= ONE)
                    return (21 * a3 - 36 * a2 + 16 * ONE) / 18;
                if (a <= 2 * ONE)
                    return (-7 * a3 + 36 * a2 - 60 * a + 32 * ONE) / 18;
                return 0;
            end
            default: begin
                return 0;
            end
        endcase
    endfunction

    function automatic pixel_result_t upscale_pixel(logic [10:0] j_idx);
        pixel_result_t r;
        longint f, w, j, left, right, k, acc, v;
        f = active_factor();
        w = active_width();
        j = j_idx;
        r.pixel = 8'd0;
        r.oor = 1'b0;
        if (j >= w * f) begin
            r.oor = 1'b1;
            return r;
        end
        left = (2 * j < f * f) ? 0 : (2 * j - f * f) / (2 * f);
        right = (2 * j + f * f) / (2 * f);
        if (right > w - 1)
            right = w - 1;
        acc = 0;
        for (k = left; k <= right; k++)
            acc += longint'(row_copy[k]) * kernel_tap_weight(kern_sel, k * f - j, f);
        if (acc >= 0) begin
            v = acc >>> FRAC;
            r.pixel = (v > 255) ? 8'd255 : v[7:0];
        end
        return r;
    endfunction

    function automatic logic [7:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_item(logic kind, logic [10:0] index, logic [7:0] value);
        request_t rq;
        rq.kind = kind;
        rq.index = index;
        rq.value = value;
        pixel_requests.push_back(rq);
        queued_count++;
    endtask

    task automatic write_register(logic [rukf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rukf_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            rukf_pkg::CFG_KERNEL: kern_sel = value[2:0];
            rukf_pkg::CFG_FACTOR: factor_reg = value[3:0];
            rukf_pkg::CFG_WIDTH: width_reg = value;
            default: ;
        endcase
    endtask

    // Stores make no result, so after the last result the block may still be writing.
    task automatic wait_drained();
        while (!(accepted_count == queued_count && predicted_pixels.size() == 0))
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Driver: offers queued requests, with random gaps while idle_on is set, and predicts on each transaction.
    request_t cur;
    logic offering;
    int send_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                if (cur.kind == rukf_pkg::REQ_STORE) begin
                    if (cur.index < ROW)
                        row_copy[cur.index[7:0]] = cur.value;
                end else begin
                    predicted_pixels.push_back(upscale_pixel(cur.index));
                end
                accepted_count++;
                offering = 1'b0;
                send_gap = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pixel_requests.size() > 0) begin
                    cur = pixel_requests.pop_front();
                    s_tdata <= {5'd0, cur.value, cur.index};
                    s_tuser <= cur.kind;
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // Monitor: checks each result transaction and paces m_tready.
    int recv_stall = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge aclk) begin
        pixel_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_pixels.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got pixel %0d flag %0d",
                             $time, m_tdata, m_tuser[0]);
                    failures++;
                end else begin
                    want = predicted_pixels.pop_front();
                    if (m_tdata !== want.pixel) begin
                        $display("%0t: pixel_out expected %0d, got %0d",
                                 $time, want.pixel, m_tdata);
                        failures++;
                    end
                    if (m_tuser[0] !== want.oor) begin
                        $display("%0t: out_of_range expected %0d, got %0d",
                                 $time, want.oor, m_tuser[0]);
                        failures++;
                    end
                end
                recv_stall = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transaction or register write happens for too long.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL row_upscale_kernel_filter_top");
                $finish;
            end
        end
    end

    initial begin
        int ph, counted, roll, span;
        logic [10:0] idx;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the whole row once so that no compute ever reads an unwritten pixel.
        for (int i = 0; i < ROW; i++)
            queue_item(rukf_pkg::REQ_STORE, 11'(i), pick_value());

        // Directed part under the reset settings: tent, factor 2, full row.
        queue_item(rukf_pkg::REQ_STORE, 11'd0, 8'd255);
        queue_item(rukf_pkg::REQ_STORE, 11'd255, 8'd0);
        queue_item(rukf_pkg::REQ_STORE, 11'd256, 8'd77);
        queue_item(rukf_pkg::REQ_STORE, 11'd2047, 8'd255);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd0, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd1, 8'd255);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd255, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd510, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd511, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd512, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd1024, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd2047, 8'd0);
        queue_item(rukf_pkg::REQ_STORE, 11'd128, 8'd255);
        queue_item(rukf_pkg::REQ_STORE, 11'd129, 8'd255);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd256, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd257, 8'd0);
        queue_item(rukf_pkg::REQ_COMPUTE, 11'd259, 8'd0);

        for (ph = 1; ph <= LAST_PHASE; ph++) begin
            wait_drained();
            if (ph <= 12) begin
                write_register(rukf_pkg::CFG_KERNEL, 9'(PHASE_KERNEL[ph-1]));
                write_register(rukf_pkg::CFG_FACTOR, 9'(PHASE_FACTOR[ph-1]));
                write_register(rukf_pkg::CFG_WIDTH, 9'(PHASE_WIDTH[ph-1]));
            end else if (ph == 13) begin
                write_register(rukf_pkg::CFG_KERNEL,
                               9'($urandom_range(rukf_pkg::KER_BOX, rukf_pkg::KER_MITCHELL)));
                write_register(rukf_pkg::CFG_FACTOR, 9'($urandom_range(1, 8)));
                write_register(rukf_pkg::CFG_WIDTH, 9'($urandom_range(1, 256)));
            end else begin
                write_register(rukf_pkg::CFG_KERNEL, 9'($urandom_range(0, 7)));
                write_register(rukf_pkg::CFG_FACTOR, 9'($urandom_range(0, 15)));
                write_register(rukf_pkg::CFG_WIDTH, 9'($urandom_range(0, 511)));
            end
            @(posedge aclk);
            cfg_we <= 1'b0;

            idle_on = (ph % 4 != 3);
            // Stall the result side for a long stretch so the block backs up its input.
            if (ph == 2 || ph == 8)
                hold_asked++;

            span = active_width() * active_factor();
            queue_item(rukf_pkg::REQ_COMPUTE, 11'd0, pick_value());
            queue_item(rukf_pkg::REQ_COMPUTE, 11'(span - 1), pick_value());
            if (span <= 2047)
                queue_item(rukf_pkg::REQ_COMPUTE, 11'(span), pick_value());
            queue_item(rukf_pkg::REQ_COMPUTE, 11'd2047, pick_value());

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 35) begin
                    if ($urandom_range(0, 9) == 0)
                        idx = 11'($urandom_range(0, 2047));
                    else
                        idx = 11'($urandom_range(0, ROW - 1));
                    queue_item(rukf_pkg::REQ_STORE, idx, pick_value());
                    if (idx < ROW)
                        counted++;
                end else begin
                    if (roll < 42)
                        idx = 11'($urandom_range(0, 2047));
                    else
                        idx = 11'($urandom_range(0, span - 1));
                    queue_item(rukf_pkg::REQ_COMPUTE, idx, pick_value());
                    counted++;
                end
            end
        end

        wait_drained();
        if (failures == 0)
            $display("PASS row_upscale_kernel_filter_top");
        else
            $display("FAIL row_upscale_kernel_filter_top");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rukf_pkg.sv
hdl/rukf_ram.sv
hdl/row_upscale_kernel_filter_top.sv
sim/tb.sv
